/* hw/rtl/tams_pkg.sv */
// Shared types and constants for the timed action activation sequencer.
// No dependencies; imported by the interfaces, the top level and tams_alu.
package tams_pkg;

    localparam int FUNC_BITS  = 2;
    localparam int SLOT_BITS  = 5;
    localparam int TRACK_BITS = 3;
    localparam int KIND_BITS  = 2;
    localparam int CNT_BITS   = 6;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_REWIND = 2'd2
    } func_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_START = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    // status from the shared compare/subtract unit
    typedef struct packed {
        logic reached;
        logic past_end;
    } cmp_flags_t;

endpackage

/* hw/rtl/tams_if.sv */
// Valid/ready channel interfaces: command transactions in, event transactions out.
// Depends on tams_pkg for the fixed field widths.
interface tams_cmd_if
    import tams_pkg::*;
#(
    parameter int TIME_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [FUNC_BITS-1:0]  func;
    logic [SLOT_BITS-1:0]  slot;
    logic [TRACK_BITS-1:0] owner_track;
    logic [TIME_BITS-1:0]  start_time;
    logic [TIME_BITS-1:0]  stop_time;
    logic [TIME_BITS-1:0]  now_time;

    modport source (output valid, func, slot, owner_track, start_time, stop_time, now_time,
                    input ready);
    modport sink   (input valid, func, slot, owner_track, start_time, stop_time, now_time,
                    output ready);
endinterface

interface tams_evt_if
    import tams_pkg::*;
#(
    parameter int TIME_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [SLOT_BITS-1:0]  event_slot;
    logic [KIND_BITS-1:0]  event_kind;
    logic [TIME_BITS-1:0]  elapsed;
    logic [TRACK_BITS-1:0] event_track;
    logic [CNT_BITS-1:0]   track_active;
    logic                  last_event;

    modport source (output valid, event_slot, event_kind, elapsed, event_track, track_active,
                    last_event, input ready);
    modport sink   (input valid, event_slot, event_kind, elapsed, event_track, track_active,
                    last_event, output ready);
endinterface

/* hw/rtl/timed_action_activation_sequencer.sv */
// Top level of the timed action activation sequencer: control, marks, counts, output.
// Depends on tams_pkg, tams_if, tams_table and tams_alu.
//
//  port     dir   handshake        carries
//  cmd      in    valid/ready      func, slot, owner_track, start/stop/now times
//  evt      out   valid/ready      slot, kind, elapsed, track, track count, last flag
//  cfg      in    cfg_we           entries_in_use
//
// A tick walks the entries in use, one entry per cycle through the table read port
// and the compare unit while the event side does not stall. One event is
// held back so the final one can carry the last flag. cmd.ready is low for the
// whole walk. Reset clears marks, counts and the register; the table is not cleared.
module timed_action_activation_sequencer
    import tams_pkg::*;
#(
    parameter int MAX_ENTRIES = 32,
    parameter int MAX_TRACKS  = 8,
    parameter int TIME_BITS   = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    tams_cmd_if.sink            cmd,
    tams_evt_if.source          evt,
    input  logic                cfg_we,
    input  logic [CNT_BITS-1:0] cfg_wdata
);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int TRK_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0]     slot;
        kind_t                kind;
        logic [TIME_BITS-1:0] elapsed;
        logic [TRK_W-1:0]     track;
        logic [CNT_BITS-1:0]  active;
    } ev_t;

    state_t               state_reg, state_next;
    logic [CNT_BITS-1:0]  entries_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [CNT_W-1:0]     lim_reg;
    logic [CNT_W-1:0]     fetch_reg;
    logic [IDX_W-1:0]     eval_idx_reg;
    logic                 eval_valid_reg;
    logic [MAX_ENTRIES-1:0] marks_reg;
    logic [CNT_BITS-1:0]  counts_reg [MAX_TRACKS];
    ev_t                  pend_reg;
    logic                 pend_valid_reg;
    ev_t                  out_reg;
    logic                 out_last_reg;
    logic                 out_valid_reg;

    logic                 accept;
    logic                 slot_ok;
    logic [TRK_W-1:0]     trk_in;
    logic                 is_load;
    logic                 is_tick;
    logic                 is_rewind;
    logic                 fetch_more;
    logic                 fetch_go;
    logic [TIME_BITS-1:0] rd_begin;
    logic [TIME_BITS-1:0] rd_end;
    logic [TRK_W-1:0]     rd_track;
    logic [TIME_BITS-1:0] elapsed;
    cmp_flags_t           flags;
    logic                 mark_cur;
    logic [CNT_BITS-1:0]  cnt_cur;
    logic [CNT_BITS-1:0]  cnt_new;
    logic                 has_event;
    kind_t                kind_new;
    logic                 out_free;
    logic                 can_push;
    logic                 stall;
    logic                 proceed;
    logic                 push_walk;
    logic                 push_flush;

    assign accept  = cmd.valid && cmd.ready;
    assign slot_ok = (int'(cmd.slot) < MAX_ENTRIES);
    assign trk_in  = (int'(cmd.owner_track) >= MAX_TRACKS) ? TRK_W'(MAX_TRACKS - 1)
                                                           : TRK_W'(cmd.owner_track);

    always_comb
    begin
        is_load   = 1'b0;
        is_tick   = 1'b0;
        is_rewind = 1'b0;
        unique case (func_t'(cmd.func))
            FUNC_LOAD:   is_load   = accept;
            FUNC_TICK:   is_tick   = accept;
            FUNC_REWIND: is_rewind = accept;
            default:     ;
        endcase
    end

    tams_table #(
        .DEPTH     (MAX_ENTRIES),
        .IDX_W     (IDX_W),
        .TIME_BITS (TIME_BITS),
        .TRK_W     (TRK_W)
    ) u_table (
        .clk    (clk),
        .we     (is_load && slot_ok),
        .waddr  (IDX_W'(cmd.slot)),
        .wbegin (cmd.start_time),
        .wend   (cmd.stop_time),
        .wtrack (trk_in),
        .re     (fetch_go),
        .raddr  (fetch_reg[IDX_W-1:0]),
        .rbegin (rd_begin),
        .rend   (rd_end),
        .rtrack (rd_track)
    );

    tams_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .now_time    (now_reg),
        .begin_time  (rd_begin),
        .finish_time (rd_end),
        .elapsed     (elapsed),
        .flags       (flags)
    );

    // evaluation of the entry whose table data is registered
    assign mark_cur  = marks_reg[eval_idx_reg];
    assign cnt_cur   = counts_reg[rd_track];
    assign has_event = eval_valid_reg && flags.reached && (mark_cur || !flags.past_end);

    always_comb
    begin
        if (!mark_cur)
        begin
            kind_new = KIND_START;
            cnt_new  = cnt_cur + CNT_BITS'(1);
        end
        else if (flags.past_end)
        begin
            kind_new = KIND_END;
            cnt_new  = cnt_cur - CNT_BITS'(1);
        end
        else
        begin
            kind_new = KIND_RUN;
            cnt_new  = cnt_cur;
        end
    end

    assign out_free   = !out_valid_reg || evt.ready;
    assign can_push   = !pend_valid_reg || out_free;
    assign stall      = has_event && !can_push;
    assign proceed    = eval_valid_reg && !stall;
    assign fetch_more = (fetch_reg < lim_reg);
    assign fetch_go   = (state_reg == ST_WALK) && !stall && fetch_more;
    assign push_walk  = has_event && pend_valid_reg && out_free;
    assign push_flush = (state_reg == ST_FLUSH) && pend_valid_reg && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (is_tick)
                    state_next = ST_WALK;
            ST_WALK:
                if (!stall && !fetch_more)
                    state_next = ST_FLUSH;
            ST_FLUSH:
                if (!pend_valid_reg || out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            entries_reg    <= '0;
            eval_valid_reg <= 1'b0;
            fetch_reg      <= '0;
            lim_reg        <= '0;
            marks_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int t = 0; t < MAX_TRACKS; t++)
                counts_reg[t] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                entries_reg <= cfg_wdata;

            if (is_tick)
            begin
                fetch_reg <= '0;
                lim_reg   <= (int'(entries_reg) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                               : CNT_W'(entries_reg);
            end
            else if (fetch_go)
                fetch_reg <= fetch_reg + CNT_W'(1);

            if (!stall)
                eval_valid_reg <= fetch_go;

            if (is_load && slot_ok)
                marks_reg[IDX_W'(cmd.slot)] <= 1'b0;
            else if (is_rewind)
            begin
                marks_reg <= '0;
                for (int t = 0; t < MAX_TRACKS; t++)
                    counts_reg[t] <= '0;
            end
            else if (proceed && has_event)
            begin
                marks_reg[eval_idx_reg] <= (kind_new != KIND_END);
                counts_reg[rd_track]    <= cnt_new;
            end

            // held-back event: refilled by every new event, drained at walk end
            if (proceed && has_event)
                pend_valid_reg <= 1'b1;
            else if (push_flush)
                pend_valid_reg <= 1'b0;

            if ((proceed && push_walk) || push_flush)
                out_valid_reg <= 1'b1;
            else if (evt.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_tick)
            now_reg <= cmd.now_time;
        if (fetch_go)
            eval_idx_reg <= fetch_reg[IDX_W-1:0];
        if (proceed && has_event)
            pend_reg <= '{slot: eval_idx_reg, kind: kind_new, elapsed: elapsed,
                          track: rd_track, active: cnt_new};
        if ((proceed && push_walk) || push_flush)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= push_flush;
        end
    end

    assign cmd.ready        = (state_reg == ST_IDLE);
    assign evt.valid        = out_valid_reg;
    assign evt.event_slot   = SLOT_BITS'(out_reg.slot);
    assign evt.event_kind   = out_reg.kind;
    assign evt.elapsed      = out_reg.elapsed;
    assign evt.event_track  = TRACK_BITS'(out_reg.track);
    assign evt.track_active = out_reg.active;
    assign evt.last_event   = out_last_reg;

    a_eval_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        eval_valid_reg |-> (state_reg == ST_WALK))
        else $error("entry under evaluation outside a walk");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held-back event left over after a tick");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> ($stable(eval_idx_reg) && eval_valid_reg))
        else $error("stalled entry moved on");

    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) && push_flush |=> (state_reg == ST_IDLE) && evt.valid)
        else $error("final event not delivered on leaving flush");
endmodule

/* hw/rtl/tams_table.sv */
// Action table memory: begin time, end time and track per entry.
// One write port, one registered read port. No dependencies.
module tams_table #(
    parameter int DEPTH     = 32,
    parameter int IDX_W     = 5,
    parameter int TIME_BITS = 32,
    parameter int TRK_W     = 3
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  logic [TIME_BITS-1:0] wbegin,
    input  logic [TIME_BITS-1:0] wend,
    input  logic [TRK_W-1:0]     wtrack,
    input  logic                 re,
    input  logic [IDX_W-1:0]     raddr,
    output logic [TIME_BITS-1:0] rbegin,
    output logic [TIME_BITS-1:0] rend,
    output logic [TRK_W-1:0]     rtrack
);
    logic [TIME_BITS-1:0] begin_mem [DEPTH];
    logic [TIME_BITS-1:0] end_mem   [DEPTH];
    logic [TRK_W-1:0]     track_mem [DEPTH];

    logic [TIME_BITS-1:0] rbegin_reg;
    logic [TIME_BITS-1:0] rend_reg;
    logic [TRK_W-1:0]     rtrack_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            begin_mem[waddr] <= wbegin;
            end_mem[waddr]   <= wend;
            track_mem[waddr] <= wtrack;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rbegin_reg <= begin_mem[raddr];
            rend_reg   <= end_mem[raddr];
            rtrack_reg <= track_mem[raddr];
        end
    end

    assign rbegin = rbegin_reg;
    assign rend   = rend_reg;
    assign rtrack = rtrack_reg;
endmodule

/* hw/rtl/tams_alu.sv */
// Shared subtract/compare unit, used once per walked entry.
// Depends on tams_pkg for the flag struct.
module tams_alu
    import tams_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic [TIME_BITS-1:0] now_time,
    input  logic [TIME_BITS-1:0] begin_time,
    input  logic [TIME_BITS-1:0] finish_time,
    output logic [TIME_BITS-1:0] elapsed,
    output cmp_flags_t           flags
);
    logic [TIME_BITS:0] diff;

    // borrow out of the subtract means begin time not yet reached
    assign diff           = {1'b0, now_time} - {1'b0, begin_time};
    assign elapsed        = diff[TIME_BITS-1:0];
    assign flags.reached  = ~diff[TIME_BITS];
    assign flags.past_end = (now_time > finish_time);
endmodule
